// ===== hdl/spq_pkg.sv =====
// Shared types, constants and codes for the slot pool with ready queue.
`default_nettype none

package spq_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = 4;
   localparam int PTR_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ST_W  = 3;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_ENQUEUE = 2'd2;
   localparam logic [1:0] OP_DEQUEUE = 2'd3;

   localparam logic [ST_W-1:0] ST_OK          = 3'd0;
   localparam logic [ST_W-1:0] ST_POOL_FULL   = 3'd1;
   localparam logic [ST_W-1:0] ST_QUEUE_FULL  = 3'd2;
   localparam logic [ST_W-1:0] ST_QUEUE_EMPTY = 3'd3;
   localparam logic [ST_W-1:0] ST_NOT_IN_USE  = 3'd4;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [IDX_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [IDX_W-1:0] result_index;
      logic [CNT_W-1:0] used_count;
   } rsp_type;

   typedef struct packed {
      logic    fire;
      req_type req;
   } cmd_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [IDX_W-1:0] result_index;
      logic [CNT_W-1:0] used_count;
   } pool_res_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [IDX_W-1:0] result_index;
   } ring_res_type;

endpackage

`default_nettype wire

// ===== hdl/spq_slot_pool.sv =====
// Slot bitmap with lowest-free allocation and used-slot count.
`default_nettype none

module spq_slot_pool (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire spq_pkg::cmd_type      cmd,
   output spq_pkg::pool_res_type      res
);

   logic [spq_pkg::SLOTS-1:0]  in_use_ff, in_use_in;
   logic [spq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       free_found;
   logic [spq_pkg::PTR_W-1:0]  free_idx;
   logic                       idx_ok;
   logic [spq_pkg::PTR_W-1:0]  rel_idx;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = spq_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = spq_pkg::PTR_W'(i);
         end
      end
   end

   assign idx_ok  = 32'(cmd.req.slot_index) < spq_pkg::SLOTS;
   assign rel_idx = spq_pkg::PTR_W'(cmd.req.slot_index);

   always_comb begin
      in_use_in        = in_use_ff;
      count_in         = count_ff;
      res.status       = spq_pkg::ST_OK;
      res.result_index = '0;
      unique case (cmd.req.opcode)
         spq_pkg::OP_ALLOC: begin
            if (free_found) begin
               res.result_index = spq_pkg::IDX_W'(free_idx);
               if (cmd.fire) begin
                  in_use_in[free_idx] = 1'b1;
                  count_in            = count_ff + 1'b1;
               end
            end else begin
               res.status = spq_pkg::ST_POOL_FULL;
            end
         end
         spq_pkg::OP_RELEASE: begin
            if (idx_ok && in_use_ff[rel_idx]) begin
               if (cmd.fire) begin
                  in_use_in[rel_idx] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end else begin
               res.status = spq_pkg::ST_NOT_IN_USE;
            end
         end
         default: begin
         end
      endcase
      res.used_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         count_ff  <= '0;
      end else begin
         in_use_ff <= in_use_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/spq_ready_ring.sv =====
// Ring queue of ready slot indices with fill count.
`default_nettype none

module spq_ready_ring (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire spq_pkg::cmd_type      cmd,
   output spq_pkg::ring_res_type      res
);

   logic [spq_pkg::IDX_W-1:0] ring_ff [spq_pkg::SLOTS];
   logic [spq_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [spq_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [spq_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic                      push;
   logic                      idx_ok;
   logic                      full;
   logic                      empty;

   assign idx_ok = 32'(cmd.req.slot_index) < spq_pkg::SLOTS;
   assign full   = fill_ff == spq_pkg::CNT_W'(spq_pkg::SLOTS);
   assign empty  = fill_ff == '0;

   always_comb begin
      wr_ptr_in        = wr_ptr_ff;
      rd_ptr_in        = rd_ptr_ff;
      fill_in          = fill_ff;
      push             = 1'b0;
      res.status       = spq_pkg::ST_OK;
      res.result_index = '0;
      unique case (cmd.req.opcode)
         spq_pkg::OP_ENQUEUE: begin
            if (!idx_ok) begin
               res.status = spq_pkg::ST_NOT_IN_USE;
            end else if (full) begin
               res.status = spq_pkg::ST_QUEUE_FULL;
            end else if (cmd.fire) begin
               push      = 1'b1;
               wr_ptr_in = (wr_ptr_ff == spq_pkg::PTR_W'(spq_pkg::SLOTS - 1)) ?
                           '0 : wr_ptr_ff + 1'b1;
               fill_in   = fill_ff + 1'b1;
            end
         end
         spq_pkg::OP_DEQUEUE: begin
            if (empty) begin
               res.status = spq_pkg::ST_QUEUE_EMPTY;
            end else begin
               res.result_index = ring_ff[rd_ptr_ff];
               if (cmd.fire) begin
                  rd_ptr_in = (rd_ptr_ff == spq_pkg::PTR_W'(spq_pkg::SLOTS - 1)) ?
                              '0 : rd_ptr_ff + 1'b1;
                  fill_in   = fill_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ring_ff[wr_ptr_ff] <= cmd.req.slot_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/slot_pool_with_ready_queue.sv =====
// Top level: slot pool with ready queue, request register and response register.
//
//   channel | ports                          | carries
//   --------+--------------------------------+-------------------------------
//   req     | req_valid, req_stall, req_data | opcode, slot_index
//   rsp     | rsp_valid, rsp_stall, rsp_data | status, result_index, used_count
//
// One transaction per cycle sustained while rsp_stall is low; a request passes through the request
// register, then the pool and ring update into the response register.
// State changes when a request moves into the response register, so requests
// are handled strictly in order. Reset is synchronous and needs no clearing pass.
// A stalled response holds the request register; req_stall rises only when both are full.
`default_nettype none

module slot_pool_with_ready_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire spq_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output spq_pkg::rsp_type       rsp_data
);

   logic                  s1_valid_ff, s1_valid_in;
   spq_pkg::req_type      s1_req_ff;
   logic                  out_valid_ff, out_valid_in;
   spq_pkg::rsp_type      out_ff, out_in;
   logic                  advance;
   logic                  accept;
   spq_pkg::cmd_type      cmd;
   spq_pkg::pool_res_type pool_res;
   spq_pkg::ring_res_type ring_res;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign cmd.fire = advance;
   assign cmd.req  = s1_req_ff;

   spq_slot_pool u_pool (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (pool_res)
   );

   spq_ready_ring u_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (ring_res)
   );

   always_comb begin
      out_in.used_count = pool_res.used_count;
      if (s1_req_ff.opcode == spq_pkg::OP_ALLOC || s1_req_ff.opcode == spq_pkg::OP_RELEASE) begin
         out_in.status       = pool_res.status;
         out_in.result_index = pool_res.result_index;
      end else begin
         out_in.status       = ring_res.status;
         out_in.result_index = ring_res.result_index;
      end
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.used_count) <= spq_pkg::SLOTS)
      else $error("used count beyond pool size");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spq_pkg::ST_POOL_FULL) |->
      32'(rsp_data.used_count) == spq_pkg::SLOTS)
      else $error("pool full reported with free slots");

   a_err_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != spq_pkg::ST_OK) |-> rsp_data.result_index == '0)
      else $error("non-zero index on failed transaction");

   a_hold_s1: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("request register lost a held transaction");
`endif

endmodule

`default_nettype wire

// ===== sim/spq_outcome_checker.sv =====
// Checker for the slot pool: tracks pool and ready ring state and scores every response.
`timescale 1ns / 1ps

module spq_outcome_checker
   import spq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_data,
   output int               fail_count,
   output int               pending,
   output int               checked,
   output logic [4:0][15:0] status_tally
);

   logic [SLOTS-1:0] slot_busy;
   logic [CNT_W-1:0] busy_total;
   logic [IDX_W-1:0] ready_fifo [SLOTS];
   logic [PTR_W-1:0] fifo_wr;
   logic [PTR_W-1:0] fifo_rd;
   logic [CNT_W-1:0] fifo_level;
   rsp_type          awaited_rsp [$];
   rsp_type          want;
   int               mismatches;
   int               scored;

   function automatic logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] p);
      return (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   // Applies one request to the pool and ring copy, returns the response it should give.
   function automatic rsp_type pool_outcome(req_type r);
      rsp_type o;
      bit      claimed;
      o.status       = ST_OK;
      o.result_index = '0;
      claimed        = 1'b0;
      case (r.opcode)
         OP_ALLOC: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (!claimed && !slot_busy[s]) begin
                  slot_busy[s]   = 1'b1;
                  busy_total     = busy_total + 1'b1;
                  o.result_index = IDX_W'(s);
                  claimed        = 1'b1;
               end
            end
            if (!claimed)
               o.status = ST_POOL_FULL;
         end
         OP_RELEASE: begin
            if (slot_busy[r.slot_index]) begin
               slot_busy[r.slot_index] = 1'b0;
               busy_total = busy_total - 1'b1;
            end else begin
               o.status = ST_NOT_IN_USE;
            end
         end
         OP_ENQUEUE: begin
            if (fifo_level == CNT_W'(SLOTS)) begin
               o.status = ST_QUEUE_FULL;
            end else begin
               ready_fifo[fifo_wr] = r.slot_index;
               fifo_wr    = ring_step(fifo_wr);
               fifo_level = fifo_level + 1'b1;
            end
         end
         default: begin
            if (fifo_level == '0) begin
               o.status = ST_QUEUE_EMPTY;
            end else begin
               o.result_index = ready_fifo[fifo_rd];
               fifo_rd    = ring_step(fifo_rd);
               fifo_level = fifo_level - 1'b1;
            end
         end
      endcase
      o.used_count = busy_total;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         slot_busy    = '0;
         busy_total   = '0;
         fifo_wr      = '0;
         fifo_rd      = '0;
         fifo_level   = '0;
         mismatches   = 0;
         scored       = 0;
         awaited_rsp.delete();
         status_tally <= '0;
      end else begin
         // response side first: a request taken at this edge cannot be answered yet
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: response with no transaction outstanding: status %0d index %0d count %0d",
                        $time, rsp_data.status, rsp_data.result_index, rsp_data.used_count);
            end else begin
               want = awaited_rsp.pop_front();
               scored++;
               status_tally[want.status] <= status_tally[want.status] + 1'b1;
               if (rsp_data.status !== want.status ||
                   rsp_data.result_index !== want.result_index ||
                   rsp_data.used_count !== want.used_count) begin
                  mismatches++;
                  $display("%0t: expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
                           $time, want.status, want.result_index, want.used_count,
                           rsp_data.status, rsp_data.result_index, rsp_data.used_count);
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_rsp.push_back(pool_outcome(req_data));
      end
      fail_count <= mismatches;
      pending    <= awaited_rsp.size();
      checked    <= scored;
   end

endmodule

// ===== sim/slot_pool_with_ready_queue_tb.sv =====
// Testbench top: drives requests and response stalls, instantiates block and checker, gives the verdict.
`timescale 1ns / 1ps

module slot_pool_with_ready_queue_tb;
   import spq_pkg::*;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

   localparam int LIMIT         = 400000;
   localparam int RANDOM_ITEMS  = 1750;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   int               fail_count;
   int               pending;
   int               checked;
   logic [4:0][15:0] status_tally;
   int               src_gap_pct = 0;
   int               dst_stall_pct = 0;
   int               op_sent [4] = '{default: 0};
   int               cycle_count = 0;

   always #5 clock = ~clock;

   slot_pool_with_ready_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   spq_outcome_checker outcome_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked),
      .status_tally (status_tally)
   );

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < dst_stall_pct);
   end

   // Holds the transaction until the block takes it; valid stays high into the next one unless a random gap drops it.
   task automatic issue(logic [1:0] op, logic [IDX_W-1:0] slot);
      while ($urandom_range(99) < src_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.opcode     <= op;
      req_data.slot_index <= slot;
      op_sent[op]++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic random_traffic(int count);
      int           left;
      int           burst;
      int           roll;
      traffic_mix_t mix;
      logic [1:0]   op;
      left = count;
      while (left > 0) begin
         mix   = traffic_mix_t'($urandom_range(2));
         burst = $urandom_range(8, 40);
         for (int n = 0; n < burst && left > 0; n++) begin
            roll = $urandom_range(99);
            case (mix)
               MIX_FILL:  op = (roll < 45) ? OP_ALLOC : (roll < 90) ? OP_ENQUEUE :
                               (roll < 95) ? OP_RELEASE : OP_DEQUEUE;
               MIX_DRAIN: op = (roll < 45) ? OP_RELEASE : (roll < 90) ? OP_DEQUEUE :
                               (roll < 95) ? OP_ALLOC : OP_ENQUEUE;
               default:   op = (roll < 25) ? OP_ALLOC : (roll < 50) ? OP_RELEASE :
                               (roll < 75) ? OP_ENQUEUE : OP_DEQUEUE;
            endcase
            issue(op, IDX_W'($urandom_range(SLOTS - 1)));
            left--;
         end
      end
   endtask

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("slot_pool_with_ready_queue regression: fail");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      src_gap_pct   = 37;
      dst_stall_pct = 74;

      // empty ring, full pool, double release, enqueue of a free slot
      issue(OP_DEQUEUE, 4'd15);
      for (int n = 0; n < SLOTS; n++)
         issue(OP_ALLOC, IDX_W'(SLOTS - 1 - n));
      issue(OP_ALLOC, 4'd0);
      issue(OP_RELEASE, 4'd15);
      issue(OP_RELEASE, 4'd15);
      issue(OP_ENQUEUE, 4'd15);
      issue(OP_ENQUEUE, 4'd0);
      issue(OP_DEQUEUE, 4'd0);
      issue(OP_DEQUEUE, 4'd15);
      drain_all();

      random_traffic(RANDOM_ITEMS / 3);
      drain_all();
      src_gap_pct   = 74;
      dst_stall_pct = 37;
      random_traffic(RANDOM_ITEMS / 3);
      drain_all();
      src_gap_pct   = 0;
      dst_stall_pct = 0;
      random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      drain_all();
      repeat (8) @(posedge clock);

      $display("requests sent: %0d allocate, %0d release, %0d enqueue, %0d dequeue",
               op_sent[OP_ALLOC], op_sent[OP_RELEASE], op_sent[OP_ENQUEUE], op_sent[OP_DEQUEUE]);
      $display("%0d responses scored; pool full %0d, queue full %0d, queue empty %0d, not in use %0d",
               checked, status_tally[ST_POOL_FULL], status_tally[ST_QUEUE_FULL],
               status_tally[ST_QUEUE_EMPTY], status_tally[ST_NOT_IN_USE]);
      if (fail_count == 0)
         $display("slot_pool_with_ready_queue regression: pass");
      else
         $display("slot_pool_with_ready_queue regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/spq_pkg.sv
hdl/spq_slot_pool.sv
hdl/spq_ready_ring.sv
hdl/slot_pool_with_ready_queue.sv
sim/spq_outcome_checker.sv
sim/slot_pool_with_ready_queue_tb.sv
